### rtl/assert_macros.svh
// assertion macros included by the rtl decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/tfd_pkg.sv
// constants, codes and crc helper for the tag frame decoder
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

    // default payload buffer depth
    localparam int unsigned PAYLOAD_DEPTH_DEF = 32;

    // crc-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // printable ascii range
    localparam logic [7:0] ASCII_LO = 8'h20;
    localparam logic [7:0] ASCII_HI = 8'h7E;

    // register reset values
    localparam logic [7:0] VERSION_RST = 8'h01;
    localparam logic [5:0] MIN_LEN_RST = 6'd2;
    localparam logic [5:0] MAX_LEN_RST = 6'd30;

    // byte counter limit and framing overhead (version, length, four crc bytes)
    localparam logic [8:0] COUNT_MAX      = 9'd511;
    localparam logic [8:0] OVERHEAD_BYTES = 9'd6;
    localparam logic [8:0] CRC_BYTES      = 9'd4;
    localparam logic [8:0] HDR_BYTES      = 9'd2;

    // configuration register indexes
    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_MIN_LEN = 2'd1;
    localparam logic [1:0] REG_MAX_LEN = 2'd2;

    // status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_VERSION = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_ASCII   = 3'd4,
        ST_CRC     = 3'd5
    } t_status;

    // result kinds
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // one byte of the reflected crc update
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/tag_frame_decoder_core.sv
// Tag frame decoder: checks version, length, ascii payload and crc-32 of byte-wise tags.
// Input stream s_axis: one tag byte per request in tdata, tlast on the final byte.
// Output stream m_axis: results; tuser is the kind (0 status, 1 payload byte),
// tlast marks the last result caused by a final byte.
// Config channel i_cfg_*: index 0 expected version, 1 min length, 2 max length;
// always ready, write only while the block is idle.
// Non-final bytes are taken back to back while idle. After a final byte the
// status stage reads the frame registers and loads the status into the output
// register once it is free. A valid tag then streams its payload from the
// buffer memory through a registered read at one byte per cycle while the
// receiver does not stall; the input is held off until the last payload byte
// sits in the output register.
// Reset (synchronous, active low) clears config to 1/2/30, the frame state and
// the output valid; the payload memory has no reset and needs no clearing pass.
// When the receiver stalls, the output register holds its result and the
// status or payload stage waits; input bytes are still taken while the last
// result of a tag waits.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tag_frame_decoder_core #(
    parameter int unsigned PAYLOAD_DEPTH = tfd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] tag_byte
    input  wire logic        s_axis_tlast,   // final_byte
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [2:0] status_code, [10:3] payload_byte,
                                             // [18:11] payload_length, [23:19] zero
    output logic             m_axis_tuser,   // item_kind
    output logic             m_axis_tlast,   // run_end
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);
    localparam logic [8:0]  DEPTH9 = 9'(PAYLOAD_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_STATUS = 3'b010,
        S_DRAIN  = 3'b100
    } t_state;

    // configuration registers
    logic [7:0] r_exp_version;
    logic [5:0] r_min_len;
    logic [5:0] r_max_len;

    // frame state
    t_state      r_state;
    logic [8:0]  r_count;
    logic [7:0]  r_len;
    logic [31:0] r_crc;
    logic [31:0] r_rx_crc;
    logic        r_ver_bad;
    logic        r_ascii_bad;

    // payload buffer and read side
    logic [7:0]    r_mem [PAYLOAD_DEPTH];
    logic [7:0]    r_mem_q;
    logic [CW-1:0] r_cnt;
    logic          r_pend;

    // output register
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [7:0]    r_out_byte;
    logic [7:0]    r_out_len;
    logic          r_out_kind;
    logic          r_out_end;

    logic             in_req;
    logic             out_free;
    logic [8:0]       idx;
    logic [8:0]       trl;
    logic             is_payload;
    logic             mem_we;
    logic             byte_bad;
    tfd_pkg::t_status st;
    logic             st_end;
    logic             load_status;
    logic             rd_issue;
    logic             load_pay;
    logic             drain_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // position of the incoming byte inside the tag
    assign idx        = r_count - tfd_pkg::HDR_BYTES;
    assign trl        = idx - {1'b0, r_len};
    assign is_payload = (r_count >= tfd_pkg::HDR_BYTES) && (idx < {1'b0, r_len});
    assign mem_we     = in_req && is_payload && (idx < DEPTH9);
    assign byte_bad   = (s_axis_tdata < tfd_pkg::ASCII_LO) || (s_axis_tdata > tfd_pkg::ASCII_HI);

    // status checks in priority order
    always_comb begin
        if (r_count < tfd_pkg::OVERHEAD_BYTES) begin
            st = tfd_pkg::ST_SHORT;
        end else if (r_ver_bad) begin
            st = tfd_pkg::ST_VERSION;
        end else if ({1'b0, r_count} != ({2'b0, r_len} + {1'b0, tfd_pkg::OVERHEAD_BYTES})) begin
            st = tfd_pkg::ST_LENGTH;
        end else if (r_ascii_bad || (r_len < {2'b0, r_min_len}) || (r_len > {2'b0, r_max_len})
                     || ({1'b0, r_len} > DEPTH9)) begin
            st = tfd_pkg::ST_ASCII;
        end else if (r_rx_crc != ~r_crc) begin
            st = tfd_pkg::ST_CRC;
        end else begin
            st = tfd_pkg::ST_OK;
        end
    end

    assign st_end      = (st != tfd_pkg::ST_OK) || (r_len == 8'd0);
    assign load_status = (r_state == S_STATUS) && out_free;

    // drain: one read in flight, next read issued as the previous byte moves out
    assign rd_issue   = (r_state == S_DRAIN) && (9'(r_cnt) < {1'b0, r_len})
                        && (!r_pend || out_free);
    assign load_pay   = (r_state == S_DRAIN) && r_pend && out_free;
    assign drain_last = load_pay && (9'(r_cnt) == {1'b0, r_len});

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= tfd_pkg::VERSION_RST;
            r_min_len     <= tfd_pkg::MIN_LEN_RST;
            r_max_len     <= tfd_pkg::MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tfd_pkg::REG_VERSION: r_exp_version <= i_cfg_data;
                tfd_pkg::REG_MIN_LEN: r_min_len     <= i_cfg_data[5:0];
                tfd_pkg::REG_MAX_LEN: r_max_len     <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // payload buffer; no read and write can meet since input is held during drain
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[idx[AW-1:0]] <= s_axis_tdata;
        end
        if (rd_issue) begin
            r_mem_q <= r_mem[r_cnt[AW-1:0]];
        end
    end

    // frame state and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_len       <= '0;
            r_crc       <= tfd_pkg::CRC_INIT;
            r_rx_crc    <= '0;
            r_ver_bad   <= 1'b0;
            r_ascii_bad <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_req) begin
                        if (r_count == 9'd0) begin
                            r_ver_bad <= (s_axis_tdata != r_exp_version);
                        end else if (r_count == 9'd1) begin
                            r_len <= s_axis_tdata;
                        end else if (is_payload) begin
                            if (byte_bad) begin
                                r_ascii_bad <= 1'b1;
                            end
                            r_crc <= tfd_pkg::crc_byte(r_crc, s_axis_tdata);
                        end else if (trl < tfd_pkg::CRC_BYTES) begin
                            r_rx_crc <= r_rx_crc | ({24'd0, s_axis_tdata} << {trl[1:0], 3'b000});
                        end
                        if (r_count < tfd_pkg::COUNT_MAX) begin
                            r_count <= r_count + 9'd1;
                        end
                        if (s_axis_tlast) begin
                            r_state <= S_STATUS;
                        end
                    end
                end
                S_STATUS: begin
                    if (load_status) begin
                        r_cnt  <= '0;
                        r_pend <= 1'b0;
                        if (st_end) begin
                            r_state     <= S_IDLE;
                            r_count     <= '0;
                            r_len       <= '0;
                            r_crc       <= tfd_pkg::CRC_INIT;
                            r_rx_crc    <= '0;
                            r_ver_bad   <= 1'b0;
                            r_ascii_bad <= 1'b0;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (rd_issue) begin
                        r_cnt  <= r_cnt + CW'(1);
                        r_pend <= 1'b1;
                    end else if (load_pay) begin
                        r_pend <= 1'b0;
                    end
                    if (drain_last) begin
                        r_state     <= S_IDLE;
                        r_count     <= '0;
                        r_len       <= '0;
                        r_crc       <= tfd_pkg::CRC_INIT;
                        r_rx_crc    <= '0;
                        r_ver_bad   <= 1'b0;
                        r_ascii_bad <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_status || load_pay) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load_status) begin
            r_out_kind   <= tfd_pkg::KIND_STATUS;
            r_out_status <= st;
            r_out_byte   <= 8'd0;
            r_out_len    <= r_len;
            r_out_end    <= st_end;
        end else if (load_pay) begin
            r_out_kind   <= tfd_pkg::KIND_PAYLOAD;
            r_out_status <= tfd_pkg::ST_OK;
            r_out_byte   <= r_mem_q;
            r_out_len    <= r_len;
            r_out_end    <= (9'(r_cnt) == {1'b0, r_len});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_len, r_out_byte, r_out_status};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_end;

    // checks
    `ASSERT_IMPLY(a_pend_in_drain, i_clk, i_rst_n, r_pend, r_state == S_DRAIN,
        "read in flight outside drain")
    `ASSERT_IMPLY(a_drain_bound, i_clk, i_rst_n, r_state == S_DRAIN,
        9'(r_cnt) <= {1'b0, r_len}, "drain read past declared length")
    `ASSERT_IMPLY(a_payload_ok, i_clk, i_rst_n, r_out_valid && r_out_kind == tfd_pkg::KIND_PAYLOAD,
        r_out_status == tfd_pkg::ST_OK, "payload result with nonzero status")
    `ASSERT_ALWAYS(a_status_entry, i_clk, i_rst_n,
        $rose(r_state == S_STATUS) |-> $past(in_req && s_axis_tlast),
        "status stage entered without a final byte")

endmodule

`default_nettype wire
